@@ src/occd_pkg.sv @@
package occd_pkg;

   localparam int MAX_WORDS  = 128;
   localparam int CNT_W      = $clog2(MAX_WORDS + 2);
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam logic [15:0] FOLD_MASK = 16'hffff;

   typedef struct packed {
      logic [31:0] word;
      logic        add;
      logic        last;
      logic        err;
      logic [31:0] seed;
   } entry_type;

endpackage

@@ src/ones_complement_checksum_diff.sv @@
// A final item passes through the queue and the b, c and output registers before its result shows.
// Throughput: one word per cycle from a two-entry queue into the accumulator; rsp_ready can stall.
// The fold and seed addition run in two registered stages behind the accumulator.
// Reset (synchronous, active high) clears the word count, accumulator, carry, queue and
// all valid flags; no result is pending after reset.
module ones_complement_checksum_diff (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_word,
   input  logic        req_invert,
   input  logic        req_word_present,
   input  logic        req_last,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_checksum,
   output logic        rsp_status
);
   import occd_pkg::*;

   entry_type push_data;
   entry_type q_data;
   logic      push_valid, push_ready;
   logic      q_valid, q_ready;

   occd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .req_invert       (req_invert),
      .req_word_present (req_word_present),
      .req_last         (req_last),
      .req_seed         (req_seed),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   occd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   occd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_data       (q_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_checksum (rsp_checksum),
      .rsp_status   (rsp_status)
   );

endmodule

@@ src/occd_front.sv @@
module occd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_word,
   input  logic                req_invert,
   input  logic                req_word_present,
   input  logic                req_last,
   input  logic [31:0]         req_seed,
   output logic                push_valid,
   input  logic                push_ready,
   output occd_pkg::entry_type push_data
);
   import occd_pkg::*;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] cnt_next;
   logic             accept;

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = accept;

   always_comb begin
      if (req_word_present && (cnt_ff <= CNT_W'(MAX_WORDS))) begin
         cnt_next = cnt_ff + CNT_W'(1);
      end else begin
         cnt_next = cnt_ff;
      end
      push_data.word = req_invert ? ~req_word : req_word;
      push_data.add  = req_word_present && (cnt_next <= CNT_W'(MAX_WORDS));
      push_data.last = req_last;
      push_data.err  = cnt_next > CNT_W'(MAX_WORDS);
      push_data.seed = req_seed;
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = req_last ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_WORDS + 1))
      else $error("word count beyond saturation");

endmodule

@@ src/occd_fifo.sv @@
module occd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  occd_pkg::entry_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output occd_pkg::entry_type out_data
);
   import occd_pkg::*;

   entry_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] cnt_ff, cnt_in;
   logic               push;
   logic               pop;

   assign in_ready  = cnt_ff != FIFO_CW'(FIFO_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FIFO_AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_ptr_cnt: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (cnt_ff == '0 || cnt_ff == FIFO_CW'(FIFO_DEPTH)))
      else $error("queue pointers disagree with fill count");

endmodule

@@ src/occd_back.sv @@
module occd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  occd_pkg::entry_type q_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_checksum,
   output logic                rsp_status
);
   import occd_pkg::*;

   typedef struct packed {
      logic        valid;
      logic        err;
      logic [31:0] acc;
      logic        carry;
      logic [31:0] seed;
   } raw_type;

   typedef struct packed {
      logic        valid;
      logic        err;
      logic [16:0] fold;
      logic [31:0] seed;
   } part_type;

   logic [31:0] acc_ff, acc_in;
   logic        carry_ff, carry_in;
   raw_type     b_ff, b_in;
   part_type    c_ff, c_in;
   logic        o_valid_ff, o_valid_in;
   logic [31:0] o_sum_ff, o_sum_in;
   logic        o_err_ff, o_err_in;

   logic        o_ready, c_ready, b_ready, pop;
   logic [31:0] acc_add, acc_next;
   logic        carry_next;
   logic [31:0] r0;
   logic [16:0] f2, f3;
   logic [32:0] s33;

   assign o_ready = !o_valid_ff || rsp_ready;
   assign c_ready = !c_ff.valid || o_ready;
   assign b_ready = !b_ff.valid || c_ready;
   assign q_ready = !q_data.last || b_ready;
   assign pop     = q_valid && q_ready;

   always_comb begin
      acc_add = acc_ff + {31'b0, carry_ff} + q_data.word;
      if (q_data.add) begin
         acc_next   = acc_add;
         carry_next = q_data.word > acc_add;
      end else begin
         acc_next   = acc_ff;
         carry_next = carry_ff;
      end

      acc_in   = acc_ff;
      carry_in = carry_ff;
      if (pop) begin
         acc_in   = q_data.last ? '0 : acc_next;
         carry_in = q_data.last ? 1'b0 : carry_next;
      end

      b_in = b_ff;
      if (b_ready) begin
         b_in.valid = pop && q_data.last;
         b_in.err   = q_data.err;
         b_in.acc   = acc_next;
         b_in.carry = carry_next;
         b_in.seed  = q_data.seed;
      end

      r0   = b_ff.acc + {31'b0, b_ff.carry};
      c_in = c_ff;
      if (c_ready) begin
         c_in.valid = b_ff.valid;
         c_in.err   = b_ff.err;
         c_in.fold  = {1'b0, r0[15:0] & FOLD_MASK} + {1'b0, r0[31:16]};
         c_in.seed  = b_ff.seed;
      end

      f2  = {1'b0, c_ff.fold[15:0]} + {16'b0, c_ff.fold[16]};
      f3  = {1'b0, f2[15:0]} + {16'b0, f2[16]};
      s33 = {1'b0, c_ff.seed} + {16'b0, f3};
      o_valid_in = o_valid_ff;
      o_sum_in   = o_sum_ff;
      o_err_in   = o_err_ff;
      if (o_ready) begin
         o_valid_in = c_ff.valid;
         o_err_in   = c_ff.err;
         o_sum_in   = c_ff.err ? '0 : s33[31:0] + {31'b0, s33[32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         carry_ff   <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         carry_ff   <= carry_in;
         b_ff.valid <= b_in.valid;
         c_ff.valid <= c_in.valid;
         o_valid_ff <= o_valid_in;
      end
      b_ff.err   <= b_in.err;
      b_ff.acc   <= b_in.acc;
      b_ff.carry <= b_in.carry;
      b_ff.seed  <= b_in.seed;
      c_ff.err   <= c_in.err;
      c_ff.fold  <= c_in.fold;
      c_ff.seed  <= c_in.seed;
      o_sum_ff   <= o_sum_in;
      o_err_ff   <= o_err_in;
   end

   assign rsp_valid    = o_valid_ff;
   assign rsp_checksum = o_sum_ff;
   assign rsp_status   = o_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_checksum == '0))
      else $error("error transfer carries a non-zero checksum");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && q_data.last) |=> (acc_ff == '0 && !carry_ff))
      else $error("accumulator not cleared after final word");

   a_last_gate: assert property (@(posedge clock) disable iff (reset)
      (pop && q_data.last) |=> b_ff.valid)
      else $error("final word dropped before fold stage");

endmodule
